/* design/fdl_pkg.sv */
// Shared constants, widths and the controller command type for the fractional delay line.
// Used by fdl_ctrl, fdl_dp and the top level; it depends on nothing else.
package fdl_pkg;

	// Store geometry and sample format.
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
	localparam int SAMPLE_BITS = 24;
	localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

	// Configuration register formats.
	localparam int DELAY_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int GAIN_BITS  = 18;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = GAIN_BITS;
	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(65536);

	localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_WHOLE    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_FRACTION = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_GAIN    = 2'd2;

	// Datapath widths. The blend is sample * 2^16 plus fraction * difference.
	localparam int BLEND_BITS = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int MAG_BITS   = BLEND_BITS - 1;
	localparam int LO_BITS    = 24;
	localparam int HI_BITS    = MAG_BITS - LO_BITS;
	localparam int SUM_BITS   = MAG_BITS + GAIN_BITS + 1;
	localparam int SUM_SHIFT  = FRAC_BITS + 16;
	localparam int Q_BITS     = SUM_BITS - SUM_SHIFT;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// One strobe per datapath step, issued by the controller.
	typedef struct packed {
		logic capture;
		logic read_a;
		logic read_b;
		logic take_a;
		logic blend;
		logic magnitude;
		logic gain;
		logic rounding;
		logic load_out;
	} cmd_t;

endpackage

/* design/fdl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the sample history of the delay line.
module fdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/fdl_ctrl.sv */
// Sequencing state machine of the fractional delay line.
// Depends on fdl_pkg; drives the command strobes of fdl_dp and both stream handshakes.
module fdl_ctrl
	import fdl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_B,
		ST_BLEND,
		ST_MAG,
		ST_GAIN,
		ST_ROUND,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = s_tvalid;
				cmd.read_a  = s_tvalid;
			end
			ST_READ_B: begin
				cmd.take_a = 1'b1;
				cmd.read_b = 1'b1;
			end
			ST_BLEND: cmd.blend     = 1'b1;
			ST_MAG:   cmd.magnitude = 1'b1;
			ST_GAIN:  cmd.gain      = 1'b1;
			ST_ROUND: cmd.rounding  = 1'b1;
			ST_OUT:   cmd.load_out  = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_READ_B;
					end
				end
				ST_READ_B: state_q <= ST_BLEND;
				ST_BLEND:  state_q <= ST_MAG;
				ST_MAG:    state_q <= ST_GAIN;
				ST_GAIN:   state_q <= ST_ROUND;
				ST_ROUND:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/fdl_dp.sv */
// Datapath of the fractional delay line: configuration registers, sample store,
// interpolation, gain, rounding and saturation. Depends on fdl_pkg and fdl_ram.
module fdl_dp
	import fdl_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [SAMPLE_BITS-1:0]    sample_in,
	output logic [SAMPLE_BITS-1:0]    sample_out
);

	localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (SUM_SHIFT - 1);

	logic [DELAY_BITS-1:0] delay_whole_q;
	logic [FRAC_BITS-1:0]  delay_fraction_q;
	logic [GAIN_BITS-1:0]  output_gain_q;

	logic [ADDR_BITS-1:0] wp_q;
	logic                 full_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic                          ok_q;
	logic signed [BLEND_BITS-1:0]  blend_q;
	logic                          neg_q;
	logic [MAG_BITS-1:0]           mag_q;
	logic [HI_BITS+GAIN_BITS-1:0]  hi_g_q;
	logic [LO_BITS+GAIN_BITS-1:0]  lo_g_q;
	logic [Q_BITS-1:0]             q_q;
	logic [SAMPLE_BITS-1:0]        out_q;

	logic [ADDR_BITS-1:0]          rp;
	logic [ADDR_BITS-1:0]          rp1;
	logic [ADDR_BITS-1:0]          rd_addr;
	logic                          rd_ok;
	logic                          bypass;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SAMPLE_BITS-1:0] rd_sample;
	logic signed [SAMPLE_BITS:0]   diff;
	logic [FRAC_BITS-1:0]          frac_eff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [BLEND_BITS-1:0]  prod;
	logic signed [BLEND_BITS-1:0]  blend_d;
	logic [SUM_BITS-1:0]           sum_d;
	logic [SAMPLE_BITS-1:0]        sat_d;

	// Configuration registers; writes to an unused index fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q    <= '0;
			delay_fraction_q <= '0;
			output_gain_q    <= GAIN_UNITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELAY_WHOLE:    delay_whole_q    <= DELAY_BITS'(cfg_data);
				CFG_DELAY_FRACTION: delay_fraction_q <= FRAC_BITS'(cfg_data);
				CFG_OUTPUT_GAIN:    output_gain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The read pointer is always the write pointer minus the delay.
	always_comb begin
		bypass  = (delay_whole_q == '0);
		rp      = wp_q - ADDR_BITS'(delay_whole_q);
		rp1     = rp - ADDR_BITS'(1);
		rd_addr = cmd.read_b ? rp1 : rp;
		// Until the pointer first wraps, only the entries below it have been written.
		rd_ok   = full_q || (rd_addr < wp_q);
	end

	fdl_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.blend),
		.waddr(wp_q),
		.wdata(x_q),
		.re   (cmd.read_a || cmd.read_b),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		rd_sample = ok_q ? signed'(rd_data) : '0;
		diff      = (SAMPLE_BITS + 1)'(rd_sample) - (SAMPLE_BITS + 1)'(a_q);
		frac_eff  = bypass ? '0 : delay_fraction_q;
		frac_s    = signed'({1'b0, frac_eff});
		prod      = frac_s * diff;
		blend_d   = (BLEND_BITS'(a_q) <<< FRAC_BITS) + prod;
		sum_d     = (SUM_BITS'(hi_g_q) << LO_BITS) + SUM_BITS'(lo_g_q) + ROUND_HALF;
		if (neg_q) begin
			sat_d = (q_q > Q_BITS'(SAMPLE_MIN)) ? SAMPLE_MIN : -SAMPLE_BITS'(q_q);
		end else begin
			sat_d = (q_q > Q_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_BITS'(q_q);
		end
	end

	// Write pointer and the flag that marks the store as completely written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (cmd.blend) begin
			wp_q <= wp_q + ADDR_BITS'(1);
			if (wp_q == '1) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= signed'(sample_in);
		end
		if (cmd.read_a || cmd.read_b) begin
			ok_q <= rd_ok;
		end
		if (cmd.take_a) begin
			a_q <= bypass ? x_q : rd_sample;
		end
		if (cmd.blend) begin
			blend_q <= blend_d;
		end
		if (cmd.magnitude) begin
			neg_q <= blend_q[BLEND_BITS-1];
			mag_q <= MAG_BITS'(blend_q[BLEND_BITS-1] ? -blend_q : blend_q);
		end
		if (cmd.gain) begin
			hi_g_q <= mag_q[MAG_BITS-1:LO_BITS] * output_gain_q;
			lo_g_q <= mag_q[LO_BITS-1:0] * output_gain_q;
		end
		if (cmd.rounding) begin
			q_q <= sum_d[SUM_BITS-1:SUM_SHIFT];
		end
		if (cmd.load_out) begin
			out_q <= sat_d;
		end
	end

	assign sample_out = out_q;

endmodule

/* design/fractional_delay_line_unit.sv */
// Top level of the fractional delay line with linear interpolation and output gain.
// Depends on fdl_pkg, fdl_ctrl, fdl_dp and, through the datapath, fdl_ram.
//
// Usage. Samples arrive as items on the s_ stream and leave on the m_ stream, one
// result item for every input item, in order. Each item is sample_in, a signed
// two's complement sample; the result is the sample from delay_whole items ago,
// blended toward the one before it by delay_fraction / 65536, multiplied by the
// Q2.16 output_gain, rounded to nearest with ties away from zero and saturated.
// A delay_whole of zero bypasses the store and only applies the gain.
// Configuration goes over the cfg_ write channel, which is always ready; index 0
// is delay_whole, 1 delay_fraction, 2 output_gain, and other indexes are ignored.
// Write it only while no item is in flight.
// Timing. The controller walks two reads of the single store read port, the
// interpolation, magnitude, gain product and rounding steps and the output load
// in turn; the result then shows up on m_tvalid, and only then does the block
// return to accept the next item.
// A result waiting in the output register does not stop the next item from being
// accepted; only if it is still not taken when the following result is ready does
// the controller hold in its last step. Reset returns the registers to delay 0,
// fraction 0 and unity gain. The store needs no clearing pass: entries that have
// not been written since reset read as zero.
module fractional_delay_line_unit
	import fdl_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [TDATA_BITS-1:0]     s_tdata,   // sample_in
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [TDATA_BITS-1:0]     m_tdata,   // sample_out, upper pad bits zero
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cmd_t                   cmd;
	logic [SAMPLE_BITS-1:0] sample_out;

	// Registers are plain flops, so a write always completes at once.
	assign cfg_ready = 1'b1;

	fdl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	fdl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_in (s_tdata[SAMPLE_BITS-1:0]),
		.sample_out(sample_out)
	);

	assign m_tdata = TDATA_BITS'(sample_out);

endmodule
